// ----- hw/rtl/b64se_pkg.sv -----
// Shared types, constants and a Base64 alphabet variant ('+' and '-' for 62 and 63) for the stream encoder.
package b64se_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SEXT_W  = 6;
  localparam int unsigned CARRY_W = 4;
  localparam int unsigned GRP_MAX = 4;
  localparam int unsigned CNT_W   = $clog2(GRP_MAX + 1);

  localparam logic [BYTE_W-1:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [BYTE_W-1:0] CHAR_UPPER = 8'h41;  // 'A'
  localparam logic [BYTE_W-1:0] CHAR_LOWER = 8'h61;  // 'a'
  localparam logic [BYTE_W-1:0] CHAR_DIGIT = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] CHAR_62    = 8'h2B;  // '+'
  localparam logic [BYTE_W-1:0] CHAR_63    = 8'h2D;  // '-'

  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_FOUR  = CNT_W'(4);

  // Position of the next byte within its 3-byte group
  typedef enum logic [2:0] {
    PH_BYTE0 = 3'b001,
    PH_BYTE1 = 3'b010,
    PH_BYTE2 = 3'b100
  } phase_t;

  // Characters caused by one byte, first character in slot 0
  typedef struct packed {
    logic [GRP_MAX-1:0][BYTE_W-1:0] chars;
    logic [CNT_W-1:0]               count;
    logic                           last;
  } grp_t;

  // Encoder state carried from byte to byte
  typedef struct packed {
    phase_t               phase;
    logic [CARRY_W-1:0]   carry;
  } enc_state_t;

  function automatic logic [BYTE_W-1:0] sextet_char(input logic [SEXT_W-1:0] v);
    logic [BYTE_W-1:0] v8;
    v8 = {2'b00, v};
    if (v8 < 8'd26) begin
      return CHAR_UPPER + v8;
    end else if (v8 < 8'd52) begin
      return CHAR_LOWER + (v8 - 8'd26);
    end else if (v8 < 8'd62) begin
      return CHAR_DIGIT + (v8 - 8'd52);
    end else if (v8 == 8'd62) begin
      return CHAR_62;
    end else begin
      return CHAR_63;
    end
  endfunction

endpackage

// ----- hw/rtl/b64se_if.sv -----
// Valid/ready stream interfaces for the encoder's byte and character channels.
interface b64se_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64se_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       end_of_output;

  modport source (output valid, output out_char, output end_of_output, input ready);
  modport sink   (input valid, input out_char, input end_of_output, output ready);
endinterface

// ----- hw/rtl/b64se_group.sv -----
// Combinational encoding of one byte into its group of Base64 characters.
module b64se_group (
  input  logic [b64se_pkg::BYTE_W-1:0] data_byte,
  input  logic                         last_byte,
  input  b64se_pkg::enc_state_t        state_cur,
  output b64se_pkg::enc_state_t        state_nxt,
  output b64se_pkg::grp_t              grp
);

  always_comb begin
    grp.chars = '0;
    grp.count = b64se_pkg::CNT_ONE;
    grp.last  = last_byte;
    state_nxt = state_cur;
    case (state_cur.phase)
      b64se_pkg::PH_BYTE1: begin
        grp.chars[0] = b64se_pkg::sextet_char({state_cur.carry[1:0], data_byte[7:4]});
        if (last_byte) begin
          grp.chars[1] = b64se_pkg::sextet_char({data_byte[3:0], 2'b00});
          grp.chars[2] = b64se_pkg::CHAR_PAD;
          grp.count    = b64se_pkg::CNT_THREE;
        end
        state_nxt.phase = b64se_pkg::PH_BYTE2;
        state_nxt.carry = data_byte[3:0];
      end
      b64se_pkg::PH_BYTE2: begin
        grp.chars[0] = b64se_pkg::sextet_char({state_cur.carry, data_byte[7:6]});
        grp.chars[1] = b64se_pkg::sextet_char(data_byte[5:0]);
        grp.count    = b64se_pkg::CNT_TWO;
        state_nxt.phase = b64se_pkg::PH_BYTE0;
        state_nxt.carry = '0;
      end
      default: begin
        // start of a group; an illegal phase code is taken as this too
        grp.chars[0] = b64se_pkg::sextet_char(data_byte[7:2]);
        if (last_byte) begin
          grp.chars[1] = b64se_pkg::sextet_char({data_byte[1:0], 4'b0000});
          grp.chars[2] = b64se_pkg::CHAR_PAD;
          grp.chars[3] = b64se_pkg::CHAR_PAD;
          grp.count    = b64se_pkg::CNT_FOUR;
        end
        state_nxt.phase = b64se_pkg::PH_BYTE1;
        state_nxt.carry = {2'b00, data_byte[1:0]};
      end
    endcase
    if (last_byte) begin
      state_nxt.phase = b64se_pkg::PH_BYTE0;
      state_nxt.carry = '0;
    end
  end

endmodule

// ----- hw/rtl/base64_stream_encoder.sv -----
// Top level of the streaming Base64 encoder: state, character buffer and handshakes.
//
//   channel | dir | payload                    | transfer when
//   --------+-----+----------------------------+-----------------------
//   in_s    | in  | data_byte[7:0], last_byte  | in_s.valid & in_s.ready
//   out_s   | out | out_char[7:0], end_of_output | out_s.valid & out_s.ready
//
// Each accepted byte is encoded in the cycle of its transfer and lands in a
// four-slot character buffer; characters then leave at one per cycle while
// out_s is ready, the first in the cycle after the transfer. A byte causes
// one to four characters, four characters for every three bytes over a full
// group; the one-character-per-cycle output port sets the pace.
// The next byte is taken in the cycle the last buffered character leaves, so
// there is no bubble between groups. rst_n (synchronous) empties the buffer
// and returns to the start of a group. A stall on out_s holds the buffer and
// back-pressures in_s.
module base64_stream_encoder (
  input  logic               clk,
  input  logic               rst_n,
  b64se_in_if.sink           in_s,
  b64se_out_if.source        out_s
);

  b64se_pkg::enc_state_t state_r, state_nxt, state_upd;
  b64se_pkg::grp_t       grp;

  logic [b64se_pkg::GRP_MAX-1:0][b64se_pkg::BYTE_W-1:0] chars_r, chars_nxt;
  logic [b64se_pkg::CNT_W-1:0]                          cnt_r, cnt_nxt;
  logic                                                 end_r, end_nxt;

  logic in_xfer;
  logic out_xfer;

  b64se_group u_group (
    .data_byte (in_s.data_byte),
    .last_byte (in_s.last_byte),
    .state_cur (state_r),
    .state_nxt (state_upd),
    .grp       (grp)
  );

  // Take a byte when the buffer is empty or its final character leaves now
  assign in_s.ready = (cnt_r == '0) || ((cnt_r == b64se_pkg::CNT_ONE) && out_s.ready);
  assign in_xfer    = in_s.valid && in_s.ready;
  assign out_xfer   = out_s.valid && out_s.ready;

  assign out_s.valid         = (cnt_r != '0);
  assign out_s.out_char      = chars_r[0];
  // Mark only the closing character of the message's final group
  assign out_s.end_of_output = end_r && (cnt_r == b64se_pkg::CNT_ONE);

  always_comb begin
    state_nxt = state_r;
    chars_nxt = chars_r;
    cnt_nxt   = cnt_r;
    end_nxt   = end_r;
    if (in_xfer) begin
      // load a fresh group; it replaces whatever just left
      state_nxt = state_upd;
      chars_nxt = grp.chars;
      cnt_nxt   = grp.count;
      end_nxt   = grp.last;
    end else if (out_xfer) begin
      // advance the buffer by one character
      chars_nxt = {{b64se_pkg::BYTE_W{1'b0}}, chars_r[b64se_pkg::GRP_MAX-1:1]};
      cnt_nxt   = cnt_r - b64se_pkg::CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase <= b64se_pkg::PH_BYTE0;
      state_r.carry <= '0;
      cnt_r         <= '0;
      end_r         <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      end_r   <= end_nxt;
    end
  end

  // Character slots hold payload only
  always_ff @(posedge clk) begin
    chars_r <= chars_nxt;
  end

endmodule

// ----- hw/rtl/b64se_checker.sv -----
// Port-level checks for the Base64 stream encoder, bound to its top level.
module b64se_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_end
);

  // An accepted byte always yields at least one character next cycle
  a_in_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted byte produced no character");

  // A stalled character blocks the input side
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while a character is stalled");

  // The closing character empties the encoder unless a new byte came in
  a_end_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_end && !(in_valid && in_ready)) |=> !out_valid)
    else $error("character left over after end of output");

  // Stalled character holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_char) && $stable(out_end)))
    else $error("stalled character changed");

  // An accepted final byte is followed by an offered character; the end-marker term cannot fail
  a_last_unused: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> (out_valid && !(out_end && !out_ready && !$past(in_last))))
    else $error("end marker inconsistent after final byte");

endmodule

bind base64_stream_encoder b64se_checker u_b64se_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .in_last   (in_s.last_byte),
  .out_valid (out_s.valid),
  .out_ready (out_s.ready),
  .out_char  (out_s.out_char),
  .out_end   (out_s.end_of_output)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the streaming Base64 encoder.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // One raw byte as offered on the input channel
  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  // One encoded character as expected on the output channel
  typedef struct {
    logic [7:0] ch;
    logic       eom;
  } char_item_t;

  // Alphabet packed MSB first: sextet v sits at bits [8*(63-v) +: 8]
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+-";
  localparam int unsigned QUIET_TAIL = 40;  // bytes left when idling stops

  logic clk;
  logic rst_n;

  b64se_in_if  in_ch ();
  b64se_out_if out_ch ();

  base64_stream_encoder DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_s (out_ch)
  );

  // Stimulus backlog (front is the byte on the bus) and characters still owed
  byte_item_t  byte_backlog[$];
  char_item_t  expected_chars[$];

  // Encoder state as the testbench sees it
  b64se_pkg::phase_t enc_phase;
  logic [3:0]        enc_carry;

  int unsigned err_count;
  int unsigned bytes_done;
  int unsigned msgs_done;
  int unsigned chars_done;
  int unsigned in_gap;
  int unsigned out_gap;
  int unsigned in_calm;
  int unsigned out_calm;
  int unsigned gap_len;
  int unsigned out_gap_len;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    err_count++;
    if (err_count <= 20) begin
      $display("[%0t] MISMATCH %s: got 0x%02h, want 0x%02h", $realtime, what, got, want);
    end
  endtask

  function automatic logic [7:0] sextet_ascii(input logic [5:0] v);
    return ALPHABET[8*(63-v) +: 8];
  endfunction

  function automatic void owe_char(input logic [7:0] c, input logic eom);
    char_item_t it;
    it.ch  = c;
    it.eom = eom;
    expected_chars.push_back(it);
  endfunction

  // Work out the characters that one accepted byte releases, and advance
  // the group position. A last byte flushes the leftover bits and pads with
  // '=' up to a full group of four, then returns to the start of a group.
  function automatic void encode_byte(input byte_item_t it);
    logic [7:0] b;
    b = it.data;
    case (enc_phase)
      b64se_pkg::PH_BYTE1: begin
        owe_char(sextet_ascii({enc_carry[1:0], b[7:4]}), 1'b0);
        enc_carry = b[3:0];
        if (it.last) begin
          owe_char(sextet_ascii({b[3:0], 2'b00}), 1'b0);
          owe_char(b64se_pkg::CHAR_PAD, 1'b1);
        end
        enc_phase = b64se_pkg::PH_BYTE2;
      end
      b64se_pkg::PH_BYTE2: begin
        owe_char(sextet_ascii({enc_carry, b[7:6]}), 1'b0);
        owe_char(sextet_ascii(b[5:0]), it.last);
        enc_carry = 4'h0;
        enc_phase = b64se_pkg::PH_BYTE0;
      end
      default: begin
        owe_char(sextet_ascii(b[7:2]), 1'b0);
        enc_carry = {2'b00, b[1:0]};
        if (it.last) begin
          owe_char(sextet_ascii({b[1:0], 4'h0}), 1'b0);
          owe_char(b64se_pkg::CHAR_PAD, 1'b0);
          owe_char(b64se_pkg::CHAR_PAD, 1'b1);
        end
        enc_phase = b64se_pkg::PH_BYTE1;
      end
    endcase
    if (it.last) begin
      enc_phase = b64se_pkg::PH_BYTE0;
      enc_carry = 4'h0;
    end
  endfunction

  // Draw an idle burst length (0 for none). Calm stretches with no idling
  // come and go at random, and the tail of the run is kept free of idling.
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (byte_backlog.size() < QUIET_TAIL) begin
      return 0;
    end
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 100);
      return 0;
    end
    if ($urandom_range(0, 5) == 0) begin
      return $urandom_range(1, 17);
    end
    return 0;
  endfunction

  function automatic void queue_byte(input logic [7:0] d, input logic l);
    byte_item_t it;
    it.data = d;
    it.last = l;
    byte_backlog.push_back(it);
  endfunction

  // Input driver: hold an offered byte until its transfer, then predict it
  // and pick the next one from the backlog, with idle bursts in between.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold: the offered byte must stay put until it is taken
    end else begin
      if (in_ch.valid) begin
        encode_byte(byte_backlog[0]);
        bytes_done++;
        if (byte_backlog[0].last) begin
          msgs_done++;
        end
        void'(byte_backlog.pop_front());
      end
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (byte_backlog.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        gap_len = draw_gap(in_calm);
        if (gap_len > 0) begin
          in_gap = gap_len - 1;
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid     <= 1'b1;
          in_ch.data_byte <= byte_backlog[0].data;
          in_ch.last_byte <= byte_backlog[0].last;
        end
      end
    end
  end

  // Output monitor: check every transfer against the oldest owed character,
  // and stall the encoder in random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        chars_done++;
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected character", out_ch.out_char, 8'h00);
        end else begin
          if (out_ch.out_char !== expected_chars[0].ch) begin
            report_mismatch("out_char", out_ch.out_char, expected_chars[0].ch);
          end
          if (out_ch.end_of_output !== expected_chars[0].eom) begin
            report_mismatch("end_of_output", {7'd0, out_ch.end_of_output},
                            {7'd0, expected_chars[0].eom});
          end
          void'(expected_chars.pop_front());
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_gap_len = draw_gap(out_calm);
        if (out_gap_len > 0) begin
          out_gap = out_gap_len - 1;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned msg_len;
    int unsigned queued;
    logic [7:0]  d;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.last_byte  = 1'b0;
    out_ch.ready     = 1'b0;
    enc_phase        = b64se_pkg::PH_BYTE0;
    enc_carry        = 4'h0;
    err_count        = 0;
    bytes_done       = 0;
    msgs_done        = 0;
    chars_done       = 0;
    in_gap           = 0;
    out_gap          = 0;
    in_calm          = 0;
    out_calm         = 0;

    // Last byte at the start of a group: two characters and double padding
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    // Last byte second in its group: single padding; two '+' sextets
    queue_byte(8'hFB, 1'b0);
    queue_byte(8'hEF, 1'b1);
    // Last byte closes a full group: no padding; all-'-' and all-'+'
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hFB, 1'b0);
    queue_byte(8'hEF, 1'b0);
    queue_byte(8'hBE, 1'b1);
    // Two full groups, then a last byte starting a third
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h10, 1'b0);
    queue_byte(8'h83, 1'b0);
    queue_byte(8'h10, 1'b0);
    queue_byte(8'h51, 1'b0);
    queue_byte(8'h87, 1'b0);
    queue_byte(8'h20, 1'b1);
    // Alternating patterns across a group boundary, last byte second in group
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h0F, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h3C, 1'b1);

    // Random messages: mostly short, a few longer, bytes now and then extreme
    queued = byte_backlog.size();
    while (queued < 520) begin
      msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                            : $urandom_range(1, 7);
      for (int unsigned i = 0; i < msg_len; i++) begin
        case ($urandom_range(0, 9))
          0: d = 8'h00;
          1: d = 8'hFF;
          default: d = 8'($urandom_range(0, 255));
        endcase
        queue_byte(d, i == msg_len - 1);
      end
      queued += msg_len;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every byte taken and every owed character seen
    do begin
      @(posedge clk);
    end while (byte_backlog.size() > 0 || in_ch.valid || expected_chars.size() > 0);
    // Let any stray character surface before closing
    repeat (20) @(posedge clk);

    $display("Encoded %0d bytes in %0d messages; checked %0d characters.",
             bytes_done, msgs_done, chars_done);
    $display("Covered every group position for the last byte, padding and idle bursts.");
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Timeout: %0d characters still owed", expected_chars.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/b64se_pkg.sv
hw/rtl/b64se_if.sv
hw/rtl/b64se_group.sv
hw/rtl/base64_stream_encoder.sv
hw/rtl/b64se_checker.sv
verif/tb_top.sv
